### rtl/ics_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ics_pkg
// Shared types and constants for the streaming internet checksum core.
// ----------------------------------------------------------------------------
package ics_pkg;

  // field widths
  localparam int WORD_WIDTH      = 16;
  localparam int INDEX_WIDTH     = 16;
  localparam int POS_WIDTH       = 8;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = POS_WIDTH;

  // saturation value of the word index
  localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = {INDEX_WIDTH{1'b1}};

  // reset value of the skip position (header checksum field)
  localparam logic [POS_WIDTH-1:0] SKIP_POSITION_RESET = POS_WIDTH'(5);

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SKIP_ENABLE   = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SKIP_POSITION = 1'b1;

  // one packet word held in the input register
  typedef struct packed {
    logic [WORD_WIDTH-1:0] data_word;
    logic                  odd_byte;
    logic                  last_word;
  } ics_item_t;

  // one checksum result
  typedef struct packed {
    logic [WORD_WIDTH-1:0] checksum;
    logic                  is_valid;
  } ics_result_t;

  // accumulator status for checking
  typedef struct packed {
    logic fire_last;
    logic sum_zero;
    logic idx_zero;
  } ics_stat_t;

  // settings that steer the accumulator
  typedef struct packed {
    logic                 skip_enable;
    logic [POS_WIDTH-1:0] skip_position;
  } ics_cfg_t;

endpackage

### rtl/ics_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ics_in_reg
// Input register stage: captures one packet word per transfer.
// ----------------------------------------------------------------------------
module ics_in_reg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ics_pkg::WORD_WIDTH-1:0]     in_tdata,   // data_word
  input  logic                               in_tuser,   // odd_byte
  input  logic                               in_tlast,   // last_word
  input  logic                               take,
  output logic                               item_vld,
  output ics_pkg::ics_item_t                 item
);
  import ics_pkg::*;

  logic      vld_r, vld_nxt;
  ics_item_t item_r;

  // room when empty or when the held word leaves this cycle
  assign in_tready = !vld_r || take;
  assign vld_nxt   = in_tready ? in_tvalid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload capture on transfer
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data_word <= in_tdata;
      item_r.odd_byte  <= in_tuser;
      item_r.last_word <= in_tlast;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

### rtl/ics_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ics_accum
// Ones' complement running sum with end-around carry and word index.
// ----------------------------------------------------------------------------
module ics_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_vld,
  input  ics_pkg::ics_item_t   item,
  input  ics_pkg::ics_cfg_t    cfg,
  input  logic                 out_free,
  output logic                 take,
  output logic                 res_vld,
  output ics_pkg::ics_result_t res,
  output ics_pkg::ics_stat_t   stat
);
  import ics_pkg::*;

  logic [WORD_WIDTH-1:0]  sum_r, sum_nxt;
  logic [INDEX_WIDTH-1:0] idx_r, idx_nxt;
  logic [WORD_WIDTH-1:0]  word;
  logic [WORD_WIDTH:0]    raw_sum;
  logic [WORD_WIDTH-1:0]  folded;
  logic [WORD_WIDTH-1:0]  new_sum;
  logic [WORD_WIDTH-1:0]  chk;
  logic                   skip;

  // a last word needs the result register free, others go at once
  assign take    = item_vld && (!item.last_word || out_free);
  assign res_vld = take && item.last_word;

  // odd byte keeps only the low byte
  assign word = item.odd_byte ? {{(WORD_WIDTH-8){1'b0}}, item.data_word[7:0]}
                              : item.data_word;

  assign skip = cfg.skip_enable &&
                (idx_r == {{(INDEX_WIDTH-POS_WIDTH){1'b0}}, cfg.skip_position});

  // end-around carry add
  assign raw_sum = {1'b0, sum_r} + {1'b0, word};
  assign folded  = raw_sum[WORD_WIDTH-1:0] + {{(WORD_WIDTH-1){1'b0}}, raw_sum[WORD_WIDTH]};
  assign new_sum = skip ? sum_r : folded;
  assign chk     = ~new_sum;

  // state update
  always_comb begin
    sum_nxt = sum_r;
    idx_nxt = idx_r;
    if (take) begin
      if (item.last_word) begin
        sum_nxt = '0;
        idx_nxt = '0;
      end else begin
        sum_nxt = new_sum;
        if (idx_r != INDEX_MAX) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      idx_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign res.checksum = chk;
  assign res.is_valid = (chk == '0);

  assign stat.fire_last = res_vld;
  assign stat.sum_zero  = (sum_r == '0);
  assign stat.idx_zero  = (idx_r == '0);

endmodule

### rtl/ics_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ics_out_reg
// Result register holding one checksum until the receiver takes it.
// ----------------------------------------------------------------------------
module ics_out_reg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           res_vld,
  input  ics_pkg::ics_result_t           res,
  output logic                           out_free,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ics_pkg::WORD_WIDTH-1:0] out_tdata,  // checksum
  output logic                           out_tuser   // is_valid
);
  import ics_pkg::*;

  logic        vld_r, vld_nxt;
  ics_result_t res_r;

  assign out_free = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (res_vld) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload load
  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = res_r.checksum;
  assign out_tuser  = res_r.is_valid;

endmodule

### rtl/internet_checksum_stream_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// internet_checksum_stream_core
// Streaming internet checksum over the 16-bit words of a packet.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one packet word per transfer; tdata is the word, tuser flags an
//           odd trailing byte (upper byte taken as zero), tlast ends the packet.
//   out_* : one result per packet; tdata is the complemented folded sum,
//           tuser is set when that checksum is zero (packet verifies).
//   cfg_* : write enable, register index, data; index 0 is skip enable,
//           index 1 is the word position left out of the sum (default 5).
//           Write only while no packet is in flight.
// Throughput: one word per clock unless a held result stalls a last word;
//   each word is one end-around-carry add between the input register and
//   the result register.
// Reset: clears the running sum, the word index and both stages; skip is
//   disabled and the position returns to 5.
// Stall: a held result blocks only a following last word; ordinary words keep
//   flowing into the sum while the receiver holds out_tready low.
// ----------------------------------------------------------------------------
module internet_checksum_stream_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ics_pkg::WORD_WIDTH-1:0]      in_tdata,   // data_word
  input  logic                                in_tuser,   // odd_byte
  input  logic                                in_tlast,   // last_word
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ics_pkg::WORD_WIDTH-1:0]      out_tdata,  // checksum
  output logic                                out_tuser,  // is_valid
  input  logic                                cfg_wr_en,
  input  logic [ics_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [ics_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import ics_pkg::*;

  ics_cfg_t    cfg_r;
  ics_item_t   item;
  ics_result_t res;
  ics_stat_t   stat;
  logic        item_vld;
  logic        take;
  logic        res_vld;
  logic        out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.skip_enable   <= 1'b0;
      cfg_r.skip_position <= SKIP_POSITION_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SKIP_ENABLE:   cfg_r.skip_enable   <= cfg_data[0];
        REG_SKIP_POSITION: cfg_r.skip_position <= cfg_data[POS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  ics_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .take      (take),
    .item_vld  (item_vld),
    .item      (item)
  );

  ics_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld),
    .item     (item),
    .cfg      (cfg_r),
    .out_free (out_free),
    .take     (take),
    .res_vld  (res_vld),
    .res      (res),
    .stat     (stat)
  );

  ics_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_vld    (res_vld),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // verify flag matches the checksum
  a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata == '0)))
    else $error("is_valid flag disagrees with checksum");

  // a finished packet shows up at the result port
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fire_last |=> out_tvalid)
    else $error("result lost after last word");

  // state cleared after a packet ends
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fire_last |=> (stat.sum_zero && stat.idx_zero))
    else $error("sum or index not cleared after last word");

  // input stalls only when a word is held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> item_vld)
    else $error("input stalled while input register empty");

endmodule

### verif/ics_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ics_checker
// Watches the word, result and register ports of the checksum core. It keeps
// its own running ones' complement sum, word position and skip settings, and
// queues the checksum that each last-word transfer should produce. Each
// result transfer is compared with the oldest queued checksum.
// ----------------------------------------------------------------------------
module ics_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [ics_pkg::WORD_WIDTH-1:0]      in_tdata,   // data_word
  input  logic                                in_tuser,   // odd_byte
  input  logic                                in_tlast,   // last_word
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [ics_pkg::WORD_WIDTH-1:0]      out_tdata,  // checksum
  input  logic                                out_tuser,  // is_valid
  input  logic                                cfg_wr_en,
  input  logic [ics_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [ics_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                                  err_count,
  output int                                  open_count,
  output int                                  done_count
);
  import ics_pkg::*;

  // checksums still owed by the core, oldest first
  ics_result_t checksum_q[$];

  // local copy of the accumulator and settings
  logic [WORD_WIDTH-1:0]  sum_acc;
  logic [INDEX_WIDTH-1:0] word_pos;
  ics_cfg_t               skip_cfg;

  int n_err  = 0;
  int n_done = 0;

  // 16-bit add with the carry wrapped back into bit 0
  function automatic logic [WORD_WIDTH-1:0] eac_add(input logic [WORD_WIDTH-1:0] a,
                                                    input logic [WORD_WIDTH-1:0] b);
    logic [WORD_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_WIDTH-1:0] + WORD_WIDTH'(s[WORD_WIDTH]);
  endfunction

  always @(posedge clk) begin
    ics_result_t want;
    ics_result_t got;
    logic [WORD_WIDTH-1:0] w;
    logic skip_hit;
    if (!rst_n) begin
      sum_acc                = '0;
      word_pos               = '0;
      skip_cfg.skip_enable   = 1'b0;
      skip_cfg.skip_position = SKIP_POSITION_RESET;
      checksum_q.delete();
    end else begin
      // result transfer against the oldest expectation
      if (out_tvalid && out_tready) begin
        got.checksum = out_tdata;
        got.is_valid = out_tuser;
        n_done++;
        if (checksum_q.size() == 0) begin
          $error("unexpected result: checksum %h is_valid %b", got.checksum, got.is_valid);
          n_err++;
        end else begin
          want = checksum_q.pop_front();
          if (got.checksum !== want.checksum) begin
            $error("checksum mismatch: expected %h, actual %h", want.checksum, got.checksum);
            n_err++;
          end
          if (got.is_valid !== want.is_valid) begin
            $error("is_valid mismatch: expected %b, actual %b", want.is_valid, got.is_valid);
            n_err++;
          end
        end
      end

      // word transfer into the running sum
      if (in_tvalid && in_tready) begin
        w = in_tuser ? {8'h00, in_tdata[7:0]} : in_tdata;
        skip_hit = skip_cfg.skip_enable &&
                   (word_pos == INDEX_WIDTH'(skip_cfg.skip_position));
        if (!skip_hit)
          sum_acc = eac_add(sum_acc, w);
        if (word_pos != INDEX_MAX)
          word_pos = word_pos + 1'b1;
        if (in_tlast) begin
          want.checksum = ~sum_acc;
          want.is_valid = (want.checksum == '0);
          checksum_q.push_back(want);
          sum_acc  = '0;
          word_pos = '0;
        end
      end

      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SKIP_ENABLE:   skip_cfg.skip_enable   = cfg_data[0];
          REG_SKIP_POSITION: skip_cfg.skip_position = cfg_data[POS_WIDTH-1:0];
          default: ;
        endcase
      end
    end
    err_count  <= n_err;
    done_count <= n_done;
    open_count <= checksum_q.size();
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the streaming internet checksum core. Sends
// directed corner packets, then random packets (many built to verify) under
// several skip settings, then a few short packets back to back. Both sides
// of the stream idle in random bursts except near the end.
// ----------------------------------------------------------------------------
module tb;
  import ics_pkg::*;

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [WORD_WIDTH-1:0]      in_tdata;   // data_word
  logic                       in_tuser;   // odd_byte
  logic                       in_tlast;   // last_word
  logic                       out_tvalid;
  logic                       out_tready;
  logic [WORD_WIDTH-1:0]      out_tdata;  // checksum
  logic                       out_tuser;  // is_valid
  logic                       cfg_wr_en;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  int fail_total;
  int open_total;
  int result_total;
  int words_sent = 0;

  bit quiet = 1'b0;   // no idling on either side
  bit gappy = 1'b1;   // input gaps allowed in this packet

  // settings last written, used to build verifying packets
  logic                 cur_en  = 1'b0;
  logic [POS_WIDTH-1:0] cur_pos = SKIP_POSITION_RESET;

  internet_checksum_stream_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ics_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .err_count  (fail_total),
    .open_count (open_total),
    .done_count (result_total)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop
  initial begin
    #4ms;
    $display("Some tests failed");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // end-around add, used only to build packets that verify
  function automatic logic [WORD_WIDTH-1:0] fold_add(input logic [WORD_WIDTH-1:0] a,
                                                     input logic [WORD_WIDTH-1:0] b);
    logic [WORD_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_WIDTH-1:0] + WORD_WIDTH'(s[WORD_WIDTH]);
  endfunction

  // word values leaning toward the carry corners
  function automatic logic [WORD_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 16'h8000;
      3:       return 16'h00ff;
      default: return WORD_WIDTH'($urandom);
    endcase
  endfunction

  // one word transfer, then maybe a short gap
  task automatic push_word(input logic [WORD_WIDTH-1:0] w, input logic odd,
                           input logic last);
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= odd;
    in_tlast  <= last;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    words_sent++;
    if (!quiet && gappy && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // drop valid and let every owed result drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_total != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write both registers; block must be idle
  task automatic set_skip(input logic en, input logic [POS_WIDTH-1:0] pos);
    logic [CFG_DATA_WIDTH-1:0] pad;
    pad       = CFG_DATA_WIDTH'($urandom);
    pad[0]    = en;
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SKIP_ENABLE;
    cfg_data  <= pad;
    @(posedge clk);
    cfg_index <= REG_SKIP_POSITION;
    cfg_data  <= CFG_DATA_WIDTH'(pos);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_en  = en;
    cur_pos = pos;
  endtask

  // random packet; a verifying one carries a fill word that zeroes the checksum
  task automatic send_packet(input int len, input bit verify);
    logic [WORD_WIDTH-1:0] words[];
    bit                    odd[];
    logic [WORD_WIDTH-1:0] s;
    int                    k;
    words = new[len];
    odd   = new[len];
    for (int i = 0; i < len; i++) begin
      words[i] = pick_word();
      odd[i]   = ($urandom_range(0, 7) == 0);
    end
    if (verify) begin
      k = $urandom_range(0, len - 1);
      if (cur_en && k == cur_pos)
        k = (k + 1) % len;
      odd[k]   = 1'b0;
      words[k] = '0;
      s        = '0;
      for (int i = 0; i < len; i++) begin
        if (!(cur_en && i == cur_pos))
          s = fold_add(s, odd[i] ? {8'h00, words[i][7:0]} : words[i]);
      end
      words[k] = ~s;
    end
    gappy = ($urandom_range(0, 2) != 0);
    for (int i = 0; i < len; i++)
      push_word(words[i], odd[i], i == len - 1);
  endtask

  // main sequence
  initial begin
    int plen;
    int budget;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_SKIP_ENABLE;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: skip off
    push_word(16'hffff, 1'b0, 1'b1);
    push_word(16'h0000, 1'b0, 1'b1);
    push_word(16'hffff, 1'b0, 1'b0);
    push_word(16'hffff, 1'b0, 1'b1);
    push_word(16'h8000, 1'b0, 1'b0);
    push_word(16'h8000, 1'b0, 1'b1);
    // odd byte inside the packet and at its end
    push_word(16'habcd, 1'b1, 1'b0);
    push_word(16'h1234, 1'b0, 1'b0);
    push_word(16'hff56, 1'b1, 1'b1);
    // header-sized packet, checksum field still summed
    for (int i = 0; i < 7; i++)
      push_word(16'hf00f ^ (16'h0001 << i), 1'b0, i == 6);
    wait_idle();

    // skipped word is also the last word
    set_skip(1'b1, 8'd5);
    for (int i = 0; i < 6; i++)
      push_word(16'h1357 << i, 1'b0, i == 5);
    wait_idle();
    // single-word packet that is skipped entirely
    set_skip(1'b1, 8'd0);
    push_word(16'hbeef, 1'b0, 1'b1);
    wait_idle();

    // random phases under several skip settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_skip(1'b0, POS_WIDTH'($urandom_range(0, 255)));
        1:       set_skip(1'b1, 8'd5);
        2:       set_skip(1'b1, 8'd0);
        3:       set_skip(1'b1, 8'd255);
        4:       set_skip(1'b1, POS_WIDTH'($urandom_range(0, 40)));
        default: set_skip(1'b0, 8'd255);
      endcase
      budget = 200;
      // packets that reach the far skip position
      if (ph == 3) begin
        for (int j = 0; j < 2; j++) begin
          plen = $urandom_range(256, 300);
          send_packet(plen, j == 0);
        end
      end
      while (budget > 0) begin
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        if (plen > budget)
          plen = budget;
        send_packet(plen, $urandom_range(0, 1) == 1);
        budget -= plen;
      end
      wait_idle();
    end

    // tail without idling: short packets back to back
    quiet = 1'b1;
    set_skip(1'b1, 8'd5);
    for (int j = 0; j < 6; j++)
      send_packet($urandom_range(1, 12), 1'b1);
    wait_idle();

    $display("Sent %0d words, checked %0d packet checksums over skip off/on at positions",
             words_sent, result_total);
    $display("0, 5, 255 and random, with odd bytes, verifying packets and stalls on both sides");
    if (fail_total == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
